[hw/rtl/hpao_pkg.sv]
// Shared types and constants for the hull point angular order unit.
// Used by the top level, the compare unit and the port checker; no dependencies.
`timescale 1ns / 1ps

package hpao_pkg;

    localparam int COORD_W        = 32;
    localparam int COUNT_W        = 7;
    localparam int MAX_POINTS_DEF = 64;

    // Differences to the start point need one extra bit; products and sums grow from there.
    localparam int DELTA_W = COORD_W + 1;
    localparam int PROD_W  = 2 * DELTA_W;
    localparam int ACC_W   = PROD_W + 1;

    // Multiply steps of one comparison: cross product first, squared distances after.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_CROSS_A = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CROSS_B = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DIST_AX = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DIST_AY = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DIST_BX = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DIST_BY = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic   start;
        point_t a;
        point_t b;
        point_t s;
    } cmp_req_t;

    typedef struct packed {
        logic done;
        logic ahead;
    } cmp_rsp_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SWAP_P,
        ST_SWAP_0,
        ST_SORT_RD_T,
        ST_SORT_LD_T,
        ST_SORT_CHK,
        ST_SORT_LD_B,
        ST_SORT_WAIT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } ord_state_t;

endpackage

[hw/rtl/hpao_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module hpao_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/hpao_cmp.sv]
// Angular order compare unit: one shared 33x33 multiplier and a 67-bit accumulator.
// Depends on hpao_pkg for point, request and response types and step codes.
`timescale 1ns / 1ps

module hpao_cmp (
    input  logic               clk,
    input  logic               rst_n,
    input  hpao_pkg::cmp_req_t req,
    output hpao_pkg::cmp_rsp_t rsp
);

    localparam int DW = hpao_pkg::DELTA_W;
    localparam int PW = hpao_pkg::PROD_W;
    localparam int AW = hpao_pkg::ACC_W;
    localparam int SW = hpao_pkg::STEP_W;

    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic                 alow_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg, acc_next;

    logic          busy_reg, busy_next;
    logic [SW-1:0] iss_reg, iss_next;
    logic          pvld_reg, pvld_next;
    logic [SW-1:0] pstep_reg;
    logic          lvld_reg, lvld_next;
    logic [SW-1:0] lstep_reg;
    logic          done_reg, done_next;
    logic          ahead_reg, ahead_next;

    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_out;
    logic signed [AW-1:0] prod_ext;
    logic                 issue;
    logic                 acc_zero;

    always_comb
    begin
        case (iss_reg)
            hpao_pkg::STEP_CROSS_A: begin mul_a = dax_reg; mul_b = dby_reg; end
            hpao_pkg::STEP_CROSS_B: begin mul_a = day_reg; mul_b = dbx_reg; end
            hpao_pkg::STEP_DIST_AX: begin mul_a = dax_reg; mul_b = dax_reg; end
            hpao_pkg::STEP_DIST_AY: begin mul_a = day_reg; mul_b = day_reg; end
            hpao_pkg::STEP_DIST_BX: begin mul_a = dbx_reg; mul_b = dbx_reg; end
            hpao_pkg::STEP_DIST_BY: begin mul_a = dby_reg; mul_b = dby_reg; end
            default:                begin mul_a = '0;      mul_b = '0;      end
        endcase
    end

    assign mul_out  = mul_a * mul_b;
    assign prod_ext = AW'(prod_reg);
    assign issue    = busy_reg && (iss_reg <= hpao_pkg::STEP_DIST_BY);
    assign acc_zero = (acc_reg == '0);

    always_comb
    begin
        case (pstep_reg) inside
            hpao_pkg::STEP_CROSS_A, hpao_pkg::STEP_DIST_AX:
                acc_next = prod_ext;
            hpao_pkg::STEP_DIST_AY:
                acc_next = acc_reg + prod_ext;
            hpao_pkg::STEP_CROSS_B, hpao_pkg::STEP_DIST_BX, hpao_pkg::STEP_DIST_BY:
                acc_next = acc_reg - prod_ext;
            default:
                acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        iss_next   = iss_reg;
        pvld_next  = issue;
        lvld_next  = pvld_reg;
        done_next  = 1'b0;
        ahead_next = ahead_reg;
        if (issue)
        begin
            iss_next = SW'(iss_reg + 1'b1);
        end
        // Cross product decides unless it is zero; then the distance difference decides.
        if (busy_reg && lvld_reg && lstep_reg == hpao_pkg::STEP_CROSS_B && !acc_zero)
        begin
            busy_next  = 1'b0;
            done_next  = 1'b1;
            ahead_next = !acc_reg[AW-1];
        end
        else if (busy_reg && lvld_reg && lstep_reg == hpao_pkg::STEP_DIST_BY)
        begin
            busy_next  = 1'b0;
            done_next  = 1'b1;
            ahead_next = alow_reg ? acc_reg[AW-1] : (!acc_reg[AW-1] && !acc_zero);
        end
        if (req.start)
        begin
            busy_next = 1'b1;
            iss_next  = hpao_pkg::STEP_CROSS_A;
            pvld_next = 1'b0;
            lvld_next = 1'b0;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            iss_reg   <= '0;
            pvld_reg  <= 1'b0;
            lvld_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ahead_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            iss_reg   <= iss_next;
            pvld_reg  <= pvld_next;
            lvld_reg  <= lvld_next;
            done_reg  <= done_next;
            ahead_reg <= ahead_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dax_reg  <= DW'(req.a.x) - DW'(req.s.x);
            day_reg  <= DW'(req.a.y) - DW'(req.s.y);
            dbx_reg  <= DW'(req.b.x) - DW'(req.s.x);
            dby_reg  <= DW'(req.b.y) - DW'(req.s.y);
            alow_reg <= (req.a.y <= req.s.y);
        end
        if (issue)
        begin
            prod_reg  <= mul_out;
            pstep_reg <= iss_reg;
        end
        if (pvld_reg)
        begin
            acc_reg   <= acc_next;
            lstep_reg <= pstep_reg;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.ahead = ahead_reg;

endmodule

[hw/rtl/hull_point_angular_order_unit.sv]
// Top level of the hull point angular order unit: load, start search, insertion sort, emit.
// Depends on hpao_pkg, hpao_ram (point store) and hpao_cmp (shared compare unit).
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_ready  | x, y, keep, last_in
//  out     | out_valid/out_ready| out_x, out_y, point_count, empty_set, last_out
//
// An empty set answers the cycle after last_in. With n kept points a store scan finds the
// start and a swap moves it to entry 0; each entry from 2 on is then fetched and compared
// via store reads and compare-unit runs (longer when the cross product is zero), plus a step
// when it lands in slot 1; results are read out of the store. The single store port and the
// one multiplier serialise this. Reset clears control and the kept count only. in_ready is
// low from last_in until the final result is taken; a stalled result holds.
`timescale 1ns / 1ps

module hull_point_angular_order_unit #(
    parameter int MAX_POINTS = hpao_pkg::MAX_POINTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [hpao_pkg::COORD_W-1:0]  x,
    input  logic signed [hpao_pkg::COORD_W-1:0]  y,
    input  logic                                 keep,
    input  logic                                 last_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [hpao_pkg::COORD_W-1:0]  out_x,
    output logic signed [hpao_pkg::COORD_W-1:0]  out_y,
    output logic [hpao_pkg::COUNT_W-1:0]         point_count,
    output logic                                 empty_set,
    output logic                                 last_out
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    hpao_pkg::ord_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ADDR_W-1:0] p_reg, p_next;

    hpao_pkg::point_t min_reg, min_next;
    hpao_pkg::point_t e0_reg, e0_next;
    hpao_pkg::point_t s_reg, s_next;
    hpao_pkg::point_t t_reg, t_next;
    hpao_pkg::point_t b_reg, b_next;

    logic                              out_valid_reg, out_valid_next;
    logic signed [hpao_pkg::COORD_W-1:0] out_x_reg, out_x_next;
    logic signed [hpao_pkg::COORD_W-1:0] out_y_reg, out_y_next;
    logic [hpao_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic                              empty_reg, empty_next;
    logic                              last_reg, last_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    hpao_pkg::point_t  ram_wdata, ram_rdata;

    hpao_pkg::cmp_req_t cmp_req;
    hpao_pkg::cmp_rsp_t cmp_rsp;

    logic             in_fire;
    logic             store_pt;
    logic [CNT_W-1:0] n_load;
    logic [CNT_W-1:0] i_inc;
    logic             i_last;
    logic             is_less;

    assign in_fire  = in_valid && in_ready;
    assign store_pt = keep && (cnt_reg < CNT_W'(MAX_POINTS));
    assign n_load   = store_pt ? CNT_W'(cnt_reg + 1'b1) : cnt_reg;
    assign i_inc    = CNT_W'(i_reg + 1'b1);
    assign i_last   = (i_inc == n_reg);
    assign is_less  = (ram_rdata.x < min_reg.x) ||
                      ((ram_rdata.x == min_reg.x) && (ram_rdata.y < min_reg.y));

    hpao_ram #(
        .WIDTH ($bits(hpao_pkg::point_t)),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmp_req.start = (state_reg == hpao_pkg::ST_SORT_LD_B);
    assign cmp_req.a     = t_reg;
    assign cmp_req.b     = ram_rdata;
    assign cmp_req.s     = s_reg;

    hpao_cmp u_cmp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmp_req),
        .rsp   (cmp_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hpao_pkg::ST_LOAD:
                if (in_fire && last_in)
                begin
                    state_next = (n_load == '0) ? hpao_pkg::ST_EMIT_WAIT
                                                : hpao_pkg::ST_SCAN_RD;
                end
            hpao_pkg::ST_SCAN_RD:
                state_next = hpao_pkg::ST_SCAN_CMP;
            hpao_pkg::ST_SCAN_CMP:
                state_next = i_last ? hpao_pkg::ST_SWAP_P : hpao_pkg::ST_SCAN_RD;
            hpao_pkg::ST_SWAP_P:
                state_next = hpao_pkg::ST_SWAP_0;
            hpao_pkg::ST_SWAP_0:
                state_next = (n_reg > CNT_W'(2)) ? hpao_pkg::ST_SORT_RD_T
                                                 : hpao_pkg::ST_EMIT_RD;
            hpao_pkg::ST_SORT_RD_T:
                state_next = hpao_pkg::ST_SORT_LD_T;
            hpao_pkg::ST_SORT_LD_T:
                state_next = hpao_pkg::ST_SORT_CHK;
            hpao_pkg::ST_SORT_CHK:
                if (j_reg == ADDR_W'(1))
                begin
                    state_next = i_last ? hpao_pkg::ST_EMIT_RD : hpao_pkg::ST_SORT_RD_T;
                end
                else
                begin
                    state_next = hpao_pkg::ST_SORT_LD_B;
                end
            hpao_pkg::ST_SORT_LD_B:
                state_next = hpao_pkg::ST_SORT_WAIT;
            hpao_pkg::ST_SORT_WAIT:
                if (cmp_rsp.done)
                begin
                    if (cmp_rsp.ahead)
                    begin
                        state_next = hpao_pkg::ST_SORT_CHK;
                    end
                    else
                    begin
                        state_next = i_last ? hpao_pkg::ST_EMIT_RD : hpao_pkg::ST_SORT_RD_T;
                    end
                end
            hpao_pkg::ST_EMIT_RD:
                state_next = hpao_pkg::ST_EMIT_LD;
            hpao_pkg::ST_EMIT_LD:
                state_next = hpao_pkg::ST_EMIT_WAIT;
            hpao_pkg::ST_EMIT_WAIT:
                if (out_ready)
                begin
                    state_next = last_reg ? hpao_pkg::ST_LOAD : hpao_pkg::ST_EMIT_RD;
                end
            default:
                state_next = hpao_pkg::ST_LOAD;
        endcase
    end

    // Datapath and store control
    always_comb
    begin
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        p_next         = p_reg;
        min_next       = min_reg;
        e0_next        = e0_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        count_next     = count_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        unique case (state_reg)
            hpao_pkg::ST_LOAD:
                if (in_fire)
                begin
                    if (store_pt)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = cnt_reg[ADDR_W-1:0];
                        ram_wdata.x = x;
                        ram_wdata.y = y;
                        cnt_next    = n_load;
                    end
                    if (last_in)
                    begin
                        n_next   = n_load;
                        cnt_next = '0;
                        i_next   = '0;
                        if (n_load == '0)
                        begin
                            out_valid_next = 1'b1;
                            out_x_next     = '0;
                            out_y_next     = '0;
                            count_next     = '0;
                            empty_next     = 1'b1;
                            last_next      = 1'b1;
                        end
                    end
                end
            hpao_pkg::ST_SCAN_RD:
                ram_raddr = i_reg[ADDR_W-1:0];
            hpao_pkg::ST_SCAN_CMP:
            begin
                if (i_reg == '0)
                begin
                    min_next = ram_rdata;
                    e0_next  = ram_rdata;
                    p_next   = '0;
                end
                else if (is_less)
                begin
                    min_next = ram_rdata;
                    p_next   = i_reg[ADDR_W-1:0];
                end
                i_next = i_inc;
            end
            hpao_pkg::ST_SWAP_P:
            begin
                ram_we    = 1'b1;
                ram_waddr = p_reg;
                ram_wdata = e0_reg;
            end
            hpao_pkg::ST_SWAP_0:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = min_reg;
                s_next    = min_reg;
                i_next    = (n_reg > CNT_W'(2)) ? CNT_W'(2) : '0;
            end
            hpao_pkg::ST_SORT_RD_T:
                ram_raddr = i_reg[ADDR_W-1:0];
            hpao_pkg::ST_SORT_LD_T:
            begin
                t_next = ram_rdata;
                j_next = i_reg[ADDR_W-1:0];
            end
            hpao_pkg::ST_SORT_CHK:
                if (j_reg == ADDR_W'(1))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    ram_wdata = t_reg;
                    i_next    = i_last ? '0 : i_inc;
                end
                else
                begin
                    ram_raddr = ADDR_W'(j_reg - 1'b1);
                end
            hpao_pkg::ST_SORT_LD_B:
                b_next = ram_rdata;
            hpao_pkg::ST_SORT_WAIT:
                if (cmp_rsp.done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    if (cmp_rsp.ahead)
                    begin
                        // shift the earlier entry up one place
                        ram_wdata = b_reg;
                        j_next    = ADDR_W'(j_reg - 1'b1);
                    end
                    else
                    begin
                        ram_wdata = t_reg;
                        i_next    = i_last ? '0 : i_inc;
                    end
                end
            hpao_pkg::ST_EMIT_RD:
                ram_raddr = i_reg[ADDR_W-1:0];
            hpao_pkg::ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_x_next     = ram_rdata.x;
                out_y_next     = ram_rdata.y;
                count_next     = hpao_pkg::COUNT_W'(n_reg);
                empty_next     = 1'b0;
                last_next      = i_last;
            end
            hpao_pkg::ST_EMIT_WAIT:
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    i_next         = i_inc;
                end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpao_pkg::ST_LOAD;
            cnt_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            p_reg         <= p_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg   <= min_next;
        e0_reg    <= e0_next;
        s_reg     <= s_next;
        t_reg     <= t_next;
        b_reg     <= b_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        count_reg <= count_next;
        empty_reg <= empty_next;
    end

    assign in_ready    = (state_reg == hpao_pkg::ST_LOAD);
    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign point_count = count_reg;
    assign empty_set   = empty_reg;
    assign last_out    = last_reg;

endmodule

[hw/rtl/hpao_checker.sv]
// Port-level checker for the hull point angular order unit, bound to the top level.
// Depends on hpao_pkg for field widths and the default set size.
`timescale 1ns / 1ps

module hpao_checker #(
    parameter int MAX_POINTS = hpao_pkg::MAX_POINTS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [hpao_pkg::COORD_W-1:0] out_x,
    input logic signed [hpao_pkg::COORD_W-1:0] out_y,
    input logic [hpao_pkg::COUNT_W-1:0]        point_count,
    input logic                                empty_set,
    input logic                                last_out
);

    // Hold a stalled result transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
        $stable(point_count) && $stable(last_out))
        else $error("stalled result changed");

    // No new point is taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // An empty set gives one zero result that closes the set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_set |-> last_out && point_count == '0 && out_x == '0 && out_y == '0)
        else $error("bad empty-set result");

    // A non-empty result carries a count within the store size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_set |->
        point_count != '0 && point_count <= hpao_pkg::COUNT_W'(MAX_POINTS))
        else $error("point count out of range");

    // Advance to loading right after the final result transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_out |=> in_ready && !out_valid)
        else $error("not ready for the next set");

endmodule

bind hull_point_angular_order_unit hpao_checker #(.MAX_POINTS(MAX_POINTS)) u_hpao_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for hull_point_angular_order_unit: directed table, then random sets.
// Depends on hpao_pkg and the unit's RTL; the angular order is predicted in place.
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_W        = hpao_pkg::COORD_W;
    localparam int COUNT_W        = hpao_pkg::COUNT_W;
    localparam int MAX_POINTS_DEF = hpao_pkg::MAX_POINTS_DEF;
    typedef hpao_pkg::point_t point_t;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam int RANDOM_ITEMS = 310;
    localparam int TAIL_START   = 275;

    // coordinate styles for random sets
    localparam int MODE_FULL    = 0;
    localparam int MODE_TINY    = 1;
    localparam int MODE_MID     = 2;
    localparam int MODE_EXTREME = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COUNT_W-1:0]        count;
        logic                      empty;
        logic                      last;
    } hull_result_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      keep;
        logic                      last;
        logic                      typed;
        hull_result_t              want;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      keep;
    logic                      last_in;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [COUNT_W-1:0]        point_count;
    logic                      empty_set;
    logic                      last_out;

    point_t       kept_pts[$];
    hull_result_t set_order[$];
    hull_result_t hull_order_due[$];
    stim_row_t    directed_rows[$];
    int           fault_count = 0;
    bit           tail_phase = 1'b0;
    int           ready_hold = 0;

    hull_point_angular_order_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x          (x),
        .y          (y),
        .keep       (keep),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_x      (out_x),
        .out_y      (out_y),
        .point_count(point_count),
        .empty_set  (empty_set),
        .last_out   (last_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #8ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // True when point a sorts ahead of point b about start s; products kept exact at 70 bits.
    function automatic logic angle_precedes(point_t a, point_t b, point_t s);
        logic signed [69:0] dax, day, dbx, dby, cross_prod, dist_a, dist_b;
        dax = a.x;
        dax = dax - s.x;
        day = a.y;
        day = day - s.y;
        dbx = b.x;
        dbx = dbx - s.x;
        dby = b.y;
        dby = dby - s.y;
        cross_prod = dax * dby - day * dbx;
        if (cross_prod > 0)
            return 1'b1;
        if (cross_prod < 0)
            return 1'b0;
        dist_a = dax * dax + day * day;
        dist_b = dbx * dbx + dby * dby;
        // collinear: nearer first at or below the start, farther first above it
        if (a.y <= s.y)
            return dist_a < dist_b;
        return dist_a > dist_b;
    endfunction

    function automatic void order_kept_points();
        int     n;
        int     p;
        int     j;
        point_t t;
        point_t s;
        n = kept_pts.size();
        p = 0;
        for (int i = 1; i < n; i++)
            if (kept_pts[i].x < kept_pts[p].x ||
                (kept_pts[i].x == kept_pts[p].x && kept_pts[i].y < kept_pts[p].y))
                p = i;
        t = kept_pts[0];
        kept_pts[0] = kept_pts[p];
        kept_pts[p] = t;
        s = kept_pts[0];
        for (int i = 2; i < n; i++)
        begin
            t = kept_pts[i];
            j = i;
            while (j > 1 && angle_precedes(t, kept_pts[j-1], s))
            begin
                kept_pts[j] = kept_pts[j-1];
                j--;
            end
            kept_pts[j] = t;
        end
    endfunction

    // Advance the predicted state by one transaction; results land in set_order.
    function automatic void predict_point(logic signed [COORD_W-1:0] px,
                                          logic signed [COORD_W-1:0] py,
                                          logic pk, logic pl);
        point_t       p;
        hull_result_t r;
        int           n;
        p.x = px;
        p.y = py;
        if (pk && kept_pts.size() < MAX_POINTS_DEF)
            kept_pts.push_back(p);
        if (!pl)
            return;
        n = kept_pts.size();
        if (n == 0)
        begin
            r = '{'0, '0, '0, 1'b1, 1'b1};
            set_order.push_back(r);
            return;
        end
        order_kept_points();
        for (int k = 0; k < n; k++)
        begin
            r = '{kept_pts[k].x, kept_pts[k].y, COUNT_W'(n), 1'b0, (k == n - 1)};
            set_order.push_back(r);
        end
        kept_pts.delete();
    endfunction

    // Drive one transaction from a falling edge; return at the falling edge after acceptance.
    task automatic push_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic pk, input logic pl,
                              input logic typed, input hull_result_t want);
        int gap;
        if (!tail_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        x        <= px;
        y        <= py;
        keep     <= pk;
        last_in  <= pl;
        do
            @(posedge clk);
        while (!in_ready);
        predict_point(px, py, pk, pl);
        if (typed)
            hull_order_due.push_back(want);
        else
            foreach (set_order[i])
                hull_order_due.push_back(set_order[i]);
        set_order.delete();
        @(negedge clk);
    endtask

    task automatic add_row(input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py,
                           input logic pk, input logic pl,
                           input logic typed, input hull_result_t want);
        stim_row_t row;
        row.x     = px;
        row.y     = py;
        row.keep  = pk;
        row.last  = pl;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(int mode);
        case (mode)
            MODE_FULL: return $urandom;
            MODE_TINY: return $urandom_range(0, 6) - 3;
            MODE_MID:  return $urandom_range(0, 2000) - 1000;
            default:
                case ($urandom_range(0, 5))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return '0;
                    3:       return -1;
                    4:       return 1;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    // Random stalls on the result side, released for the tail of the run.
    always @(negedge clk)
    begin
        if (tail_phase)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            ready_hold <= $urandom_range(1, 6) - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        hull_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (hull_order_due.size() == 0)
            begin
                $error("unexpected result: out_x %0d out_y %0d last_out %0b",
                       out_x, out_y, last_out);
                fault_count++;
            end
            else
            begin
                want = hull_order_due.pop_front();
                if (out_x !== want.x)
                begin
                    $error("out_x: expected %0d, got %0d", want.x, out_x);
                    fault_count++;
                end
                if (out_y !== want.y)
                begin
                    $error("out_y: expected %0d, got %0d", want.y, out_y);
                    fault_count++;
                end
                if (point_count !== want.count)
                begin
                    $error("point_count: expected %0d, got %0d", want.count, point_count);
                    fault_count++;
                end
                if (empty_set !== want.empty)
                begin
                    $error("empty_set: expected %0b, got %0b", want.empty, empty_set);
                    fault_count++;
                end
                if (last_out !== want.last)
                begin
                    $error("last_out: expected %0b, got %0b", want.last, last_out);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        int sent;
        int set_idx;
        int mode;
        int set_len;
        bit big;
        bit drop_all;
        logic pk;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        x        = '0;
        y        = '0;
        keep     = 1'b0;
        last_in  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty set right after reset, then single-point sets at the extremes
        add_row(0, 0, 1'b0, 1'b1, 1'b1, '{'0, '0, '0, 1'b1, 1'b1});
        add_row(COORD_MIN, COORD_MAX, 1'b1, 1'b1, 1'b1,
                '{COORD_MIN, COORD_MAX, 7'd1, 1'b0, 1'b1});
        add_row(COORD_MAX, COORD_MIN, 1'b1, 1'b1, 1'b1,
                '{COORD_MAX, COORD_MIN, 7'd1, 1'b0, 1'b1});
        // discarded points around one kept point, closed by a discarded last
        add_row(5, 7, 1'b0, 1'b0, 1'b0, '0);
        add_row(123, -9, 1'b1, 1'b0, 1'b0, '0);
        add_row(77, 77, 1'b0, 1'b1, 1'b1, '{32'sd123, -32'sd9, 7'd1, 1'b0, 1'b1});
        // four corners of the coordinate range
        add_row(COORD_MAX, COORD_MAX, 1'b1, 1'b0, 1'b0, '0);
        add_row(COORD_MIN, COORD_MIN, 1'b1, 1'b0, 1'b0, '0);
        add_row(COORD_MAX, COORD_MIN, 1'b1, 1'b0, 1'b0, '0);
        add_row(COORD_MIN, COORD_MAX, 1'b1, 1'b1, 1'b0, '0);
        // collinear rays above, on and below the start, with a duplicate
        add_row(0, 0, 1'b1, 1'b0, 1'b0, '0);
        add_row(3, 3, 1'b1, 1'b0, 1'b0, '0);
        add_row(1, 1, 1'b1, 1'b0, 1'b0, '0);
        add_row(2, 2, 1'b1, 1'b0, 1'b0, '0);
        add_row(2, 2, 1'b1, 1'b0, 1'b0, '0);
        add_row(4, 0, 1'b1, 1'b0, 1'b0, '0);
        add_row(2, 0, 1'b1, 1'b0, 1'b0, '0);
        add_row(0, 5, 1'b1, 1'b0, 1'b0, '0);
        add_row(0, 3, 1'b1, 1'b0, 1'b0, '0);
        add_row(2, -2, 1'b1, 1'b0, 1'b0, '0);
        add_row(1, -1, 1'b1, 1'b1, 1'b0, '0);

        foreach (directed_rows[i])
            push_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].keep,
                       directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);

        sent    = 0;
        set_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // two sets overflow the store; the rest stay small
            big      = (set_idx == 3 || set_idx == 17);
            mode     = $urandom_range(MODE_FULL, MODE_EXTREME);
            set_len  = big ? $urandom_range(66, 70) : $urandom_range(1, 9);
            drop_all = !big && $urandom_range(0, 19) == 0;
            for (int k = 0; k < set_len; k++)
            begin
                pk = big || (!drop_all && $urandom_range(0, 6) != 0);
                push_point(pick_coord(mode), pick_coord(mode), pk, k == set_len - 1,
                           1'b0, '0);
                sent++;
                tail_phase = sent >= TAIL_START;
            end
            set_idx++;
        end
        in_valid <= 1'b0;

        while (hull_order_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fault_count == 0 && hull_order_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
